### hdl/hop_route_table_engine_assert.svh
// Assertion macros shared by the route table engine.
`ifndef HOP_ROUTE_TABLE_ENGINE_ASSERT_SVH
`define HOP_ROUTE_TABLE_ENGINE_ASSERT_SVH
// Property that must hold whenever reset is low.
`define HRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property checked also during reset.
`define HRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

### hdl/hrt_pkg.sv
`timescale 1ns / 1ps
package hrt_pkg;
   localparam int DefTableDepth = 16;
   localparam logic [7:0] NO_ADDR = 8'hFF;
   localparam int ResMax = 16;

   typedef enum logic [2:0] {
      REQ_ANNOUNCE = 3'd0,
      REQ_NEIGHBOR = 3'd1,
      REQ_TICK     = 3'd2,
      REQ_LOOKUP   = 3'd3,
      REQ_ADVERTISE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_UPDATE = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_ADV    = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_LIFE_RELOAD = 1'b0,
      CSR_LIFE_DECREMENT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_ADV,
      ST_RESP,
      ST_ADV_END
   } state_type;

   typedef struct packed {
      logic [7:0] life;
      logic [7:0] node;
      logic [7:0] relay_one;
      logic [7:0] relay_two;
      logic [1:0] cost;
   } entry_type;

   // Command broadcast to every cell for one cycle.
   typedef struct packed {
      logic       shift;     // rotate the ring by one cell
      logic       tick;      // age the entry at the head
      logic       wr;        // write the head entry
      logic       set_r2;
      logic [7:0] decrement;
      entry_type  wdata;
   } cell_ctl_type;
endpackage

### hdl/hrt_if.sv
`timescale 1ns / 1ps
interface hrt_if #(parameter int W = 8) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/hrt_cell.sv
`timescale 1ns / 1ps
// One table entry. The cells form a ring; when ctl.shift is set, every
// entry moves one cell toward the head, and the head cell applies edits.
module hrt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  hrt_pkg::cell_ctl_type ctl,
   input  logic                 is_head,
   input  hrt_pkg::entry_type   from_prev,
   output hrt_pkg::entry_type   q
);
   import hrt_pkg::*;
   entry_type e_ff, e_in;
   entry_type cur;

   always_comb begin
      cur = e_ff;
      if (is_head && ctl.tick) begin
         if (e_ff.life > ctl.decrement) cur.life = e_ff.life - ctl.decrement;
         else cur.life = '0;
      end
      if (is_head && ctl.wr) begin
         cur.life = ctl.wdata.life;
         cur.node = ctl.wdata.node;
         cur.cost = ctl.wdata.cost;
         cur.relay_one = ctl.wdata.relay_one;
         if (ctl.set_r2) cur.relay_two = ctl.wdata.relay_two;
      end
      e_in = cur;
      if (ctl.shift) e_in = from_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) e_ff <= '0;
      else e_ff <= e_in;
   end
   assign q = cur;
endmodule

### hdl/hop_route_table_engine.sv
`timescale 1ns / 1ps
// Route table engine. The table lives in a ring of TABLE_DEPTH cells; the
// controller looks at the head cell only, and every scan step rotates the
// ring by one cell, so each pass walks the whole ring once and the table
// ends in its original order. An announce or neighbor record that writes
// an entry takes one pass to find the target and a second pass to write
// it; any other request takes a single pass. During an advertise the ring
// holds still while a new result waits for the held one to go out. One
// item is handled at a time; the next is taken in the cycle after the last
// result transfer of the current one. Configuration writes (csr_*) take
// effect at once and are meant for idle times only.
module hop_route_table_engine #(
   parameter int TABLE_DEPTH = hrt_pkg::DefTableDepth
) (
   input  logic       clock,
   input  logic       reset,
   hrt_if.sink        req,
   hrt_if.source      rsp,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import hrt_pkg::*;
   `include "hop_route_table_engine_assert.svh"

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Input payload: {req_type, node_addr, near_addr, far_addr}.
   // Output payload: {kind, table_full, found, first_hop, second_hop,
   // adv_near, adv_far, adv_count, last}.
   logic [2:0] req_type;
   logic [7:0] node_addr, near_addr, far_addr;
   assign {req_type, node_addr, near_addr, far_addr} = req.data;

   logic [7:0] life_reload_ff, life_decrement_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         life_reload_ff <= 8'd30;
         life_decrement_ff <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIFE_RELOAD:    life_reload_ff <= csr_wdata;
            CSR_LIFE_DECREMENT: life_decrement_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Cell ring.
   cell_ctl_type ctl;
   entry_type    q [TABLE_DEPTH];
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      hrt_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .is_head(g == 0),
         .from_prev(q[(g + 1) % TABLE_DEPTH]), .q(q[g])
      );
   end
   entry_type head;
   assign head = g_cell[0].u_cell.e_ff;

   state_type  state_ff, state_in;
   logic [2:0] op_ff;
   logic [7:0] node_ff, near_ff, far_ff, sender_ff;
   logic [IW-1:0] pos_ff;       // index of the entry now at the head
   logic [CW-1:0] cnt_ff;       // entries looked at in this pass
   logic          hit_ff;       // target found
   logic [IW-1:0] tgt_ff;
   entry_type     wr_ff;
   logic          wr_r2_ff;
   logic          wr_ok_ff;     // entry needs writing
   logic          full_ff;
   logic          fnd_ff;
   logic [7:0]    h1_ff, h2_ff;
   logic [4:0]    adv_n_ff;     // advertisement results already sent
   logic          have_ff;      // an advertisement result is held back
   logic [7:0]    an_ff, af_ff;
   logic [rsp.W-1:0] out_ff;

   wire live = head.life != 8'd0;
   wire pass_done = cnt_ff == CW'(TABLE_DEPTH);

   // The newest advertisement result is held back until the next one is
   // found or the pass ends, so that its last bit is known when it goes out.
   logic             slot_free;
   logic             adv_take;
   logic             adv_stall;
   logic             emit;
   logic [rsp.W-1:0] emit_data;
   assign slot_free = !rsp.valid || rsp.ready;
   assign adv_take = live && (head.cost == 2'd1 || head.cost == 2'd2)
                     && (adv_n_ff + 5'(have_ff)) != 5'(ResMax);
   assign adv_stall = adv_take && have_ff && !slot_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) begin
            if (req_type == REQ_ADVERTISE) state_in = ST_ADV;
            else state_in = ST_SCAN;
         end
         ST_SCAN: if (pass_done) begin
            if ((op_ff == REQ_ANNOUNCE || op_ff == REQ_NEIGHBOR) && wr_ok_ff)
               state_in = ST_WRITE;
            else state_in = ST_RESP;
         end
         ST_WRITE: if (pass_done) state_in = ST_RESP;
         ST_RESP: if (rsp.ready) state_in = ST_IDLE;
         ST_ADV: if (pass_done) state_in = ST_ADV_END;
         ST_ADV_END: if (slot_free) state_in = ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req.ready = state_ff == ST_IDLE;
      ctl = '0;
      ctl.decrement = life_decrement_ff;
      ctl.wdata = wr_ff;
      ctl.set_r2 = wr_r2_ff;
      case (state_ff)
         ST_SCAN: begin
            ctl.shift = !pass_done;
            ctl.tick = !pass_done && op_ff == REQ_TICK && live;
         end
         ST_WRITE: begin
            ctl.shift = !pass_done;
            ctl.wr = !pass_done && pos_ff == tgt_ff;
         end
         ST_ADV: ctl.shift = !pass_done && !adv_stall;
         default: ;
      endcase
   end

   // Result that is loaded into the output register in this cycle.
   always_comb begin
      emit = 1'b0;
      emit_data = out_ff;
      case (state_ff)
         ST_SCAN, ST_WRITE: if (pass_done && state_in == ST_RESP) begin
            emit = 1'b1;
            emit_data = {(op_ff == REQ_LOOKUP) ? KIND_LOOKUP : KIND_UPDATE,
                         full_ff || ((op_ff == REQ_ANNOUNCE || op_ff == REQ_NEIGHBOR)
                                     && !hit_ff && !wr_ok_ff),
                         fnd_ff, h1_ff, h2_ff, NO_ADDR, NO_ADDR, 5'd0, 1'b1};
         end
         ST_ADV: if (!pass_done && adv_take && have_ff && slot_free) begin
            emit = 1'b1;
            emit_data = {KIND_ADV, 1'b0, 1'b0, NO_ADDR, NO_ADDR, an_ff, af_ff,
                         adv_n_ff + 5'd1, 1'b0};
         end
         ST_ADV_END: if (slot_free) begin
            emit = 1'b1;
            if (have_ff)
               emit_data = {KIND_ADV, 1'b0, 1'b0, NO_ADDR, NO_ADDR, an_ff, af_ff,
                            adv_n_ff + 5'd1, 1'b1};
            else
               emit_data = {KIND_ADV, 1'b0, 1'b0, NO_ADDR, NO_ADDR, NO_ADDR, NO_ADDR,
                            5'd0, 1'b1};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sender_ff <= '0;
         rsp.valid <= 1'b0;
         pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp.valid <= 1'b1;
            out_ff <= emit_data;
         end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
         end
         if (ctl.shift) pos_ff <= (pos_ff == IW'(TABLE_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
         case (state_ff)
            ST_IDLE: if (req.valid) begin
               op_ff <= req_type; node_ff <= node_addr;
               near_ff <= near_addr; far_ff <= far_addr;
               if (req_type == REQ_ANNOUNCE) sender_ff <= node_addr;
               cnt_ff <= '0; hit_ff <= 1'b0; wr_ok_ff <= 1'b0; full_ff <= 1'b0;
               fnd_ff <= 1'b0; h1_ff <= NO_ADDR; h2_ff <= NO_ADDR;
               adv_n_ff <= '0; have_ff <= 1'b0;
               tgt_ff <= '0; wr_r2_ff <= 1'b0;
            end
            ST_SCAN: if (!pass_done) begin
               cnt_ff <= cnt_ff + 1'b1;
               case (op_ff)
                  REQ_ANNOUNCE: if (!hit_ff && live && head.node == node_ff) begin
                     hit_ff <= 1'b1; tgt_ff <= pos_ff; wr_ok_ff <= 1'b1;
                  end else if (!hit_ff && !live && !wr_ok_ff) begin
                     tgt_ff <= pos_ff; wr_ok_ff <= 1'b1;
                  end
                  REQ_NEIGHBOR: if (!hit_ff && live && head.node == near_ff) begin
                     hit_ff <= 1'b1; tgt_ff <= pos_ff;
                     wr_ok_ff <= head.cost != 2'd1; wr_r2_ff <= 1'b0;
                     wr_ff.node <= near_ff; wr_ff.cost <= 2'd2;
                  end else if (!hit_ff && live && far_ff != NO_ADDR
                               && head.node == far_ff) begin
                     hit_ff <= 1'b1; tgt_ff <= pos_ff;
                     wr_ok_ff <= head.cost == 2'd3; wr_r2_ff <= 1'b1;
                     wr_ff.node <= far_ff; wr_ff.cost <= 2'd3;
                  end else if (!hit_ff && !live && !wr_ok_ff) begin
                     tgt_ff <= pos_ff; wr_ok_ff <= 1'b1;
                     wr_r2_ff <= far_ff != NO_ADDR;
                     wr_ff.node <= (far_ff != NO_ADDR) ? far_ff : near_ff;
                     wr_ff.cost <= (far_ff != NO_ADDR) ? 2'd3 : 2'd2;
                  end
                  REQ_LOOKUP: if (head.node == node_ff && head.cost != 2'd0) begin
                     fnd_ff <= 1'b1;
                     h1_ff <= (head.cost == 2'd1) ? NO_ADDR : head.relay_one;
                     h2_ff <= (head.cost == 2'd3) ? head.relay_two : NO_ADDR;
                  end
                  default: ;
               endcase
            end else begin
               cnt_ff <= '0;
               wr_ff.life <= life_reload_ff;
               wr_ff.relay_one <= sender_ff;
               wr_ff.relay_two <= near_ff;
               if (op_ff == REQ_ANNOUNCE) begin
                  wr_ff.node <= node_ff; wr_ff.cost <= 2'd1; wr_r2_ff <= 1'b0;
               end
               if ((op_ff == REQ_ANNOUNCE || op_ff == REQ_NEIGHBOR) && !hit_ff && !wr_ok_ff)
                  full_ff <= 1'b1;
            end
            ST_WRITE: if (!pass_done) cnt_ff <= cnt_ff + 1'b1;
            ST_ADV: if (!pass_done && !adv_stall) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (adv_take) begin
                  // A held result goes out in this cycle and the head entry
                  // takes its place.
                  if (have_ff) adv_n_ff <= adv_n_ff + 5'd1;
                  have_ff <= 1'b1;
                  an_ff <= (head.cost == 2'd1) ? head.node : head.relay_one;
                  af_ff <= (head.cost == 2'd1) ? NO_ADDR : head.node;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.data = out_ff;

   `HRT_ASSERT(a_ring_home, (state_ff == ST_IDLE) |-> (pos_ff == '0), "ring not home")
   `HRT_ASSERT(a_no_req_busy, (state_ff != ST_IDLE) |-> !req.ready, "ready while busy")
   `HRT_ASSERT(a_wr_write, ctl.wr |-> (state_ff == ST_WRITE), "write outside pass")
   `HRT_ASSERT(a_rsp_hold, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)), "result dropped while waiting")
endmodule

### sim/hop_route_table_engine_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interface is hrt_if from the RTL. This file holds the
// two packed layouts that the testbench places on its data buses.
package hrt_tb_pkg;
   import hrt_pkg::*;

   typedef struct packed {
      req_code_type req_type;
      logic [7:0]   node_addr;
      logic [7:0]   near_addr;
      logic [7:0]   far_addr;
   } route_req_type;

   typedef struct packed {
      kind_type   kind;
      logic       table_full;
      logic       found;
      logic [7:0] first_hop;
      logic [7:0] second_hop;
      logic [7:0] adv_near;
      logic [7:0] adv_far;
      logic [4:0] adv_count;
      logic       last;
   } route_rsp_type;
endpackage

### sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for the route table engine. Requests go through a shadow copy of
// the route table, and each response must match the oldest predicted one.
module testbench;
   import hrt_pkg::*;
   import hrt_tb_pkg::*;

   localparam int Depth = 16;
   localparam int WatchdogLimit = 20000;

   // Holds the predicted responses and counts mismatches.
   class route_scoreboard;
      route_rsp_type pending[$];
      int            mismatches;

      function void note_request(route_rsp_type predicted[$]);
         foreach (predicted[i]) pending.push_back(predicted[i]);
      endfunction

      function void check_response(route_rsp_type got);
         route_rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [0:0] csr_index = CSR_LIFE_RELOAD;
   logic [7:0] csr_wdata = 0;

   hrt_if #(.W($bits(route_req_type))) req();
   hrt_if #(.W($bits(route_rsp_type))) rsp();

   hop_route_table_engine DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow of the table and of the configuration.
   logic [7:0] life_q[Depth];
   logic [7:0] node_q[Depth];
   logic [7:0] relay1_q[Depth];
   logic [7:0] relay2_q[Depth];
   logic [1:0] cost_q[Depth];
   logic [7:0] sender_q;
   logic [7:0] reload_q;
   logic [7:0] decrement_q;

   route_scoreboard board;
   int sender_idle_pct;
   int receiver_idle_pct;
   int idle_cycles = 0;
   bit failed;

   function automatic route_rsp_type blank_response(kind_type k);
      route_rsp_type r;
      r = '0;
      r.kind = k;
      r.first_hop = NO_ADDR;
      r.second_hop = NO_ADDR;
      r.adv_near = NO_ADDR;
      r.adv_far = NO_ADDR;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void load_entry(int j, logic [7:0] node, logic [1:0] cost,
                                      logic [7:0] r1, bit set_r2, logic [7:0] r2);
      life_q[j] = reload_q;
      node_q[j] = node;
      cost_q[j] = cost;
      relay1_q[j] = r1;
      if (set_r2) relay2_q[j] = r2;
   endfunction

   function automatic int free_slot();
      for (int j = 0; j < Depth; j++)
         if (life_q[j] == 0) return j;
      return -1;
   endfunction

   // Applies one request to the shadow table and returns its responses.
   function automatic void predict_route(route_req_type q, ref route_rsp_type res[$]);
      route_rsp_type r;
      int slot;
      bit done;
      res.delete();
      r = blank_response(KIND_UPDATE);
      case (q.req_type)
         REQ_ANNOUNCE: begin
            sender_q = q.node_addr;
            done = 0;
            for (int j = 0; j < Depth && !done; j++)
               if (life_q[j] > 0 && node_q[j] == q.node_addr) begin
                  load_entry(j, q.node_addr, 2'd1, q.node_addr, 1'b0, 8'd0);
                  done = 1;
               end
            if (!done) begin
               slot = free_slot();
               if (slot < 0) r.table_full = 1;
               else load_entry(slot, q.node_addr, 2'd1, q.node_addr, 1'b0, 8'd0);
            end
            res.push_back(r);
         end
         REQ_NEIGHBOR: begin
            done = 0;
            for (int j = 0; j < Depth && !done; j++) begin
               if (life_q[j] == 0) continue;
               if (node_q[j] == q.near_addr) begin
                  if (cost_q[j] != 1)
                     load_entry(j, q.near_addr, 2'd2, sender_q, 1'b0, 8'd0);
                  done = 1;
               end else if (q.far_addr != NO_ADDR && node_q[j] == q.far_addr) begin
                  if (cost_q[j] == 3)
                     load_entry(j, q.far_addr, 2'd3, sender_q, 1'b1, q.near_addr);
                  done = 1;
               end
            end
            if (!done) begin
               slot = free_slot();
               if (slot < 0) r.table_full = 1;
               else if (q.far_addr != NO_ADDR)
                  load_entry(slot, q.far_addr, 2'd3, sender_q, 1'b1, q.near_addr);
               else load_entry(slot, q.near_addr, 2'd2, sender_q, 1'b0, 8'd0);
            end
            res.push_back(r);
         end
         REQ_TICK: begin
            for (int j = 0; j < Depth; j++)
               if (life_q[j] > 0)
                  life_q[j] = (life_q[j] > decrement_q) ? life_q[j] - decrement_q : 8'd0;
            res.push_back(r);
         end
         REQ_LOOKUP: begin
            r = blank_response(KIND_LOOKUP);
            // The highest matching index wins, whether live or not.
            for (int j = 0; j < Depth; j++)
               if (node_q[j] == q.node_addr && cost_q[j] != 0) begin
                  r.found = 1;
                  r.first_hop = (cost_q[j] == 1) ? NO_ADDR : relay1_q[j];
                  r.second_hop = (cost_q[j] == 3) ? relay2_q[j] : NO_ADDR;
               end
            res.push_back(r);
         end
         REQ_ADVERTISE: begin
            for (int j = 0; j < Depth && res.size() < ResMax; j++) begin
               if (life_q[j] == 0 || cost_q[j] == 0 || cost_q[j] == 3) continue;
               r = blank_response(KIND_ADV);
               r.last = 0;
               r.adv_count = 5'(res.size() + 1);
               if (cost_q[j] == 1) r.adv_near = node_q[j];
               else begin
                  r.adv_near = relay1_q[j];
                  r.adv_far = node_q[j];
               end
               res.push_back(r);
            end
            if (res.size() == 0) res.push_back(blank_response(KIND_ADV));
            else res[res.size() - 1].last = 1;
         end
         default: res.push_back(r);
      endcase
   endfunction

   function automatic route_rsp_type rsp_type_cast(logic [$bits(route_rsp_type)-1:0] d);
      return route_rsp_type'(d);
   endfunction

   // Receiver side: random stalls, every accepted transfer is checked.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) board.check_response(rsp_type_cast(rsp.data));
      rsp.ready <= !reset && ($urandom_range(99) >= receiver_idle_pct);
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("hop_route_table_engine test failed");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [7:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_LIFE_RELOAD) reload_q = value;
      else decrement_q = value;
      @(posedge clock);
   endtask

   // Presents one request, predicts it on acceptance.
   task automatic send_request(req_code_type t, logic [7:0] node, logic [7:0] near_a,
                               logic [7:0] far_a);
      route_req_type q;
      route_rsp_type res[$];
      q.req_type = t;
      q.node_addr = node;
      q.near_addr = near_a;
      q.far_addr = far_a;
      while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      req.valid <= 1;
      req.data <= q;
      do @(posedge clock); while (!req.ready);
      predict_route(q, res);
      board.note_request(res);
      req.valid <= 0;
      // The engine is busy after an accepted transfer.
      @(posedge clock);
   endtask

   // Waits until every predicted response has come, then lets the engine settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * Depth + 8) @(posedge clock);
   endtask

   task automatic random_request();
      logic [7:0] pool_addr;
      int pick;
      pick = $urandom_range(99);
      // A small address pool makes matches and refreshes likely.
      pool_addr = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20));
      if (pick < 20) send_request(REQ_ANNOUNCE, pool_addr, 8'($urandom), 8'($urandom));
      else if (pick < 55)
         send_request(REQ_NEIGHBOR, 8'($urandom), 8'($urandom_range(20)),
                      ($urandom_range(2) == 0) ? NO_ADDR : 8'($urandom_range(20)));
      else if (pick < 68) send_request(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 86) send_request(REQ_LOOKUP, pool_addr, 8'($urandom), 8'($urandom));
      else if (pick < 96) send_request(REQ_ADVERTISE, 8'($urandom), 8'($urandom), 8'($urandom));
      else send_request(req_code_type'($urandom_range(7, 5)), 8'($urandom), 8'($urandom),
                        8'($urandom));
   endtask

   initial begin
      req.valid = 0;
      req.data = '0;
      board = new();
      sender_idle_pct = 14;
      receiver_idle_pct = 86;
      sender_q = 0;
      reload_q = 30;
      decrement_q = 1;
      for (int j = 0; j < Depth; j++) begin
         life_q[j] = 0; node_q[j] = 0; relay1_q[j] = 0; relay2_q[j] = 0; cost_q[j] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at reset settings: empty advertise, misses, full table.
      send_request(REQ_ADVERTISE, 8'h00, 8'h00, 8'h00);
      send_request(REQ_LOOKUP, 8'hFF, 8'h00, 8'h00);
      send_request(REQ_NEIGHBOR, 8'h00, 8'h00, NO_ADDR);
      send_request(REQ_ANNOUNCE, 8'h00, 8'h00, 8'h00);
      send_request(REQ_ANNOUNCE, 8'hFF, 8'h00, 8'h00);
      send_request(REQ_NEIGHBOR, 8'h00, 8'hAA, 8'h55);
      send_request(REQ_NEIGHBOR, 8'h00, 8'hFF, 8'h55);
      send_request(REQ_LOOKUP, 8'h55, 8'h00, 8'h00);
      send_request(REQ_LOOKUP, 8'hFF, 8'h00, 8'h00);
      for (int k = 0; k < 13; k++) send_request(REQ_NEIGHBOR, 8'h00, 8'(k + 1), NO_ADDR);
      send_request(REQ_ANNOUNCE, 8'h77, 8'h00, 8'h00);
      send_request(REQ_NEIGHBOR, 8'h00, 8'h99, 8'h98);
      send_request(REQ_ADVERTISE, 8'h00, 8'h00, 8'h00);
      send_request(req_code_type'(3'd7), 8'hFF, 8'hFF, 8'hFF);
      // Sender pauses until every expected response has come.
      drain();

      // Extreme settings: ticks clear the whole table at once.
      write_csr(CSR_LIFE_DECREMENT, 8'd255);
      write_csr(CSR_LIFE_RELOAD, 8'd255);
      send_request(REQ_TICK, 8'h00, 8'h00, 8'h00);
      send_request(REQ_LOOKUP, 8'h55, 8'h00, 8'h00);
      for (int n = 0; n < 25; n++) random_request();
      drain();

      sender_idle_pct = 86;
      receiver_idle_pct = 14;
      write_csr(CSR_LIFE_RELOAD, 8'd1);
      write_csr(CSR_LIFE_DECREMENT, 8'd1);
      for (int n = 0; n < 25; n++) random_request();
      drain();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_csr(CSR_LIFE_RELOAD, 8'd6);
      write_csr(CSR_LIFE_DECREMENT, 8'd2);
      for (int n = 0; n < 25; n++) random_request();
      drain();

      failed = (board.mismatches != 0) || (board.pending.size() != 0);
      if (!failed) $display("hop_route_table_engine test passed");
      else $display("hop_route_table_engine test failed");
      $finish;
   end
endmodule
